### src/bale_pkg.sv
// shared types and constants for the bounded array list engine
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package bale_pkg;

	localparam int WORD_W   = 32;
	localparam int POS_W    = 6;
	localparam int AT_W     = 7;
	localparam int COUNT_W  = 7;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_READ   = 2'd1,
		OP_FIND   = 2'd2,
		OP_INSERT = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_RANGE    = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	// control part of a request as it travels down the cell chain
	typedef struct packed {
		logic    vld;
		op_t     op;
		logic    ok;
		status_t status;
	} wave_ctl_t;

endpackage

### src/bale_head.sv
// request entry: element count register and up-front status decisions
// depends on bale_pkg
`timescale 1ns / 1ps

module bale_head #(
	parameter int CAPACITY = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                adv,
	input  logic                                req_valid,
	input  logic [1:0]                          operation,
	input  logic [bale_pkg::POS_W-1:0]          position,
	input  logic [bale_pkg::WORD_W-1:0]         word,
	output bale_pkg::wave_ctl_t                 ctl_q,
	output logic [bale_pkg::POS_W-1:0]          pos_q,
	output logic [bale_pkg::WORD_W-1:0]         word_q,
	output logic [$clog2(CAPACITY+1)-1:0]       cnt_q
);
	import bale_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > POS_W) ? CW : POS_W;

	logic [CW-1:0] count_q;
	op_t           op;
	logic          ok;
	status_t       st;
	logic          pos_lt;
	logic          full;
	logic          grow;

	// decide range and full status against the current count
	always_comb begin
		op     = op_t'(operation);
		pos_lt = XW'(position) < XW'(count_q);
		full   = count_q == CW'(CAPACITY);
		ok     = 1'b0;
		st     = ST_OK;
		unique case (op)
			OP_APPEND: begin
				ok = !full;
				st = full ? ST_FULL : ST_OK;
			end
			OP_READ: begin
				ok = pos_lt;
				st = pos_lt ? ST_OK : ST_RANGE;
			end
			OP_FIND: begin
				ok = 1'b1;
				st = ST_NOTFOUND;
			end
			OP_INSERT: begin
				if (!pos_lt) begin
					st = ST_RANGE;
				end else if (full) begin
					st = ST_FULL;
				end else begin
					ok = 1'b1;
				end
			end
			default: ;
		endcase
		grow = ok && (op == OP_APPEND || op == OP_INSERT);
	end

	// element count, bumped on each transfer that adds a word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (adv && req_valid && grow) begin
			count_q <= count_q + CW'(1);
		end
	end

	// first stage register of the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (adv) begin
			ctl_q.vld    <= req_valid;
			ctl_q.op     <= op;
			ctl_q.ok     <= ok;
			ctl_q.status <= st;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_q  <= position;
			word_q <= word;
			cnt_q  <= count_q;
		end
	end

endmodule

### src/bale_cell.sv
// one list cell: holds one element and acts on the request passing through
// depends on bale_pkg
`timescale 1ns / 1ps

module bale_cell #(
	parameter int CAPACITY = 64,
	parameter int IDX      = 0
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                adv,
	input  bale_pkg::wave_ctl_t                 ctl_in,
	input  logic [bale_pkg::POS_W-1:0]          pos_in,
	input  logic [bale_pkg::WORD_W-1:0]         word_in,
	input  logic [bale_pkg::WORD_W-1:0]         carry_in,
	input  logic [$clog2(CAPACITY+1)-1:0]       cnt_in,
	input  logic [$clog2(CAPACITY)-1:0]         at_in,
	input  logic [bale_pkg::WORD_W-1:0]         rd_in,
	output bale_pkg::wave_ctl_t                 ctl_q,
	output logic [bale_pkg::POS_W-1:0]          pos_q,
	output logic [bale_pkg::WORD_W-1:0]         word_q,
	output logic [bale_pkg::WORD_W-1:0]         carry_q,
	output logic [$clog2(CAPACITY+1)-1:0]       cnt_q,
	output logic [$clog2(CAPACITY)-1:0]         at_q,
	output logic [bale_pkg::WORD_W-1:0]         rd_q
);
	import bale_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam int XW = (CW > POS_W) ? CW : POS_W;

	logic [WORD_W-1:0] elem_q;
	logic [WORD_W-1:0] elem_d;
	logic              elem_we;
	wave_ctl_t         ctl_d;
	logic [WORD_W-1:0] carry_d;
	logic [IW-1:0]     at_d;
	logic [WORD_W-1:0] rd_d;
	logic [XW-1:0]     idx_x;
	logic [XW-1:0]     pos_x;
	logic [XW-1:0]     cnt_x;
	logic              hit_pos;

	// local action for the request at this cell
	always_comb begin
		idx_x   = XW'(IDX);
		pos_x   = XW'(pos_in);
		cnt_x   = XW'(cnt_in);
		hit_pos = idx_x == pos_x;
		ctl_d   = ctl_in;
		carry_d = carry_in;
		at_d    = at_in;
		rd_d    = rd_in;
		elem_we = 1'b0;
		elem_d  = carry_in;
		if (ctl_in.vld) begin
			unique case (ctl_in.op)
				OP_APPEND: begin
					if (ctl_in.ok && idx_x == cnt_x) begin
						elem_we = 1'b1;
						elem_d  = word_in;
					end
				end
				OP_READ: begin
					if (ctl_in.ok && hit_pos) begin
						rd_d = elem_q;
					end
				end
				OP_FIND: begin
					if (ctl_in.status == ST_NOTFOUND && idx_x < cnt_x
							&& elem_q == word_in) begin
						ctl_d.status = ST_OK;
						at_d         = IW'(IDX);
					end
				end
				OP_INSERT: begin
					// new word lands here, older words ripple up one cell
					if (ctl_in.ok && hit_pos) begin
						elem_we = 1'b1;
						elem_d  = word_in;
						carry_d = elem_q;
					end else if (ctl_in.ok && idx_x > pos_x && idx_x <= cnt_x) begin
						elem_we = 1'b1;
						elem_d  = carry_in;
						carry_d = elem_q;
					end
				end
				default: ;
			endcase
		end
	end

	// stored element
	always_ff @(posedge clk) begin
		if (adv && elem_we) begin
			elem_q <= elem_d;
		end
	end

	// hand the request on to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (adv) begin
			ctl_q <= ctl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_q   <= pos_in;
			word_q  <= word_in;
			carry_q <= carry_d;
			cnt_q   <= cnt_in;
			at_q    <= at_d;
			rd_q    <= rd_d;
		end
	end

endmodule

### src/bale_tail.sv
// response register: formats the result leaving the last cell
// depends on bale_pkg
`timescale 1ns / 1ps

module bale_tail #(
	parameter int CAPACITY = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                adv,
	input  bale_pkg::wave_ctl_t                 ctl_in,
	input  logic [$clog2(CAPACITY+1)-1:0]       cnt_in,
	input  logic [$clog2(CAPACITY)-1:0]         at_in,
	input  logic [bale_pkg::WORD_W-1:0]         rd_in,
	output logic                                rsp_valid,
	output logic [1:0]                          status,
	output logic [bale_pkg::WORD_W-1:0]         read_word,
	output logic [bale_pkg::AT_W-1:0]           found_at,
	output logic [bale_pkg::COUNT_W-1:0]        element_count
);
	import bale_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam int ZW = (IW > AT_W) ? IW : AT_W;
	localparam int YW = (CW > COUNT_W) ? CW : COUNT_W;

	logic [CW-1:0] cnt_new;
	logic [ZW-1:0] at_x;
	logic [YW-1:0] cnt_x;
	logic          grow;
	logic          found;

	// final count and found index
	always_comb begin
		grow    = ctl_in.ok && (ctl_in.op == OP_APPEND || ctl_in.op == OP_INSERT);
		cnt_new = cnt_in + CW'(grow);
		found   = ctl_in.op == OP_FIND && ctl_in.status == ST_OK;
		at_x    = ZW'(at_in);
		cnt_x   = YW'(cnt_new);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (adv) begin
			rsp_valid <= ctl_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ctl_in.vld) begin
			status        <= ctl_in.status;
			read_word     <= rd_in;
			found_at      <= found ? at_x[AT_W-1:0] : '1;
			element_count <= cnt_x[COUNT_W-1:0];
		end
	end

endmodule

### src/bounded_array_list_engine.sv
// Bounded ordered list of signed 32-bit words kept in a chain of CAPACITY cells.
// Operations are append, read at index, find first equal word and insert at
// index, each giving exactly one response. A request enters the chain on each
// cycle that the response side is not stalled and moves one cell per cycle
// while not stalled, so the engine takes one request per clock unless stalled;
// each response passes through the entry register, one register per cell and
// the output register. A stalled response freezes the whole chain, so req_stall
// follows rsp_stall while a response is waiting. The element store needs no
// clearing after reset.
// depends on bale_pkg, bale_head, bale_cell, bale_tail
`timescale 1ns / 1ps

module bounded_array_list_engine #(
	parameter int CAPACITY = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic [1:0]                          operation,
	input  logic [bale_pkg::POS_W-1:0]          position,
	input  logic [bale_pkg::WORD_W-1:0]         word,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic [1:0]                          status,
	output logic [bale_pkg::WORD_W-1:0]         read_word,
	output logic [bale_pkg::AT_W-1:0]           found_at,
	output logic [bale_pkg::COUNT_W-1:0]        element_count
);
	import bale_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);

	logic              adv;
	wave_ctl_t         ctl   [0:CAPACITY];
	logic [POS_W-1:0]  pos   [0:CAPACITY];
	logic [WORD_W-1:0] wrd   [0:CAPACITY];
	logic [WORD_W-1:0] carry [0:CAPACITY];
	logic [CW-1:0]     cnt   [0:CAPACITY];
	logic [IW-1:0]     at    [0:CAPACITY];
	logic [WORD_W-1:0] rd    [0:CAPACITY];

	// chain moves whenever the output register is free or being drained
	assign adv       = !rsp_valid || !rsp_stall;
	assign req_stall = !adv;

	bale_head #(
		.CAPACITY(CAPACITY)
	) u_head (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.req_valid (req_valid),
		.operation (operation),
		.position  (position),
		.word      (word),
		.ctl_q     (ctl[0]),
		.pos_q     (pos[0]),
		.word_q    (wrd[0]),
		.cnt_q     (cnt[0])
	);

	// defaults entering the first cell
	assign carry[0] = wrd[0];
	assign at[0]    = '0;
	assign rd[0]    = '0;

	// the cell chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		bale_cell #(
			.CAPACITY(CAPACITY),
			.IDX     (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.ctl_in   (ctl[i]),
			.pos_in   (pos[i]),
			.word_in  (wrd[i]),
			.carry_in (carry[i]),
			.cnt_in   (cnt[i]),
			.at_in    (at[i]),
			.rd_in    (rd[i]),
			.ctl_q    (ctl[i+1]),
			.pos_q    (pos[i+1]),
			.word_q   (wrd[i+1]),
			.carry_q  (carry[i+1]),
			.cnt_q    (cnt[i+1]),
			.at_q     (at[i+1]),
			.rd_q     (rd[i+1])
		);
	end

	bale_tail #(
		.CAPACITY(CAPACITY)
	) u_tail (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.ctl_in        (ctl[CAPACITY]),
		.cnt_in        (cnt[CAPACITY]),
		.at_in         (at[CAPACITY]),
		.rd_in         (rd[CAPACITY]),
		.rsp_valid     (rsp_valid),
		.status        (status),
		.read_word     (read_word),
		.found_at      (found_at),
		.element_count (element_count)
	);

endmodule
